FILE: hw/rtl/udpq_pkg.sv
// ----------------------------------------------------------------------------
// udpq_pkg
// Shared types and constants of the unique-key double-ended priority queue.
// ----------------------------------------------------------------------------
package udpq_pkg;

  localparam int UDPQ_CAPACITY = 1024;
  // Cells per group of the registered match tree.
  localparam int UDPQ_GROUP = 32;

  localparam int TYPE_W  = 2;
  localparam int KEY_W   = 20;
  localparam int VAL_W   = 20;
  localparam int ST_W    = 3;
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 30;

  localparam logic [TYPE_W-1:0] REQ_INSERT   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_POP_HIGH = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_POP_LOW  = 2'd2;

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [ST_W-1:0] ST_IGNORED   = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [VAL_W-1:0]  beauty;
    logic [KEY_W-1:0]  cost;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] entry_count;
    logic [SUM_W-1:0]   beauty_total;
    logic [SUM_W-1:0]   cost_total;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/udpq_req_if.sv
// ----------------------------------------------------------------------------
// udpq_req_if
// Request channel: valid/ready handshake with one request as payload.
// ----------------------------------------------------------------------------
interface udpq_req_if;
  logic            valid;
  logic            ready;
  udpq_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/udpq_rsp_if.sv
// ----------------------------------------------------------------------------
// udpq_rsp_if
// Result channel: valid/ready handshake with one result as payload.
// ----------------------------------------------------------------------------
interface udpq_rsp_if;
  logic            valid;
  logic            ready;
  udpq_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/udpq_cell.sv
// ----------------------------------------------------------------------------
// udpq_cell
// One slot of the sorted chain: holds a cost and a beauty, compares its cost
// with the broadcast key and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module udpq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  logic                      clk,
  input  logic [CNT_W-1:0]          count,
  input  udpq_pkg::cell_cmd_t       cmd,
  input  logic [udpq_pkg::KEY_W-1:0] prev_key,
  input  logic [udpq_pkg::VAL_W-1:0] prev_val,
  input  logic                      prev_lt,
  input  logic [udpq_pkg::KEY_W-1:0] next_key,
  input  logic [udpq_pkg::VAL_W-1:0] next_val,
  output logic [udpq_pkg::KEY_W-1:0] key,
  output logic [udpq_pkg::VAL_W-1:0] val,
  output logic                      lt,
  output logic                      eq,
  output logic                      top
);
  import udpq_pkg::*;

  logic occ;

  always_comb begin
    occ = count > CNT_W'(IDX);
    lt  = occ && (key < cmd.key);
    eq  = occ && (key == cmd.key);
    top = count == CNT_W'(IDX + 1);
  end

  // On an insert, entries below the new cost stay; the first cell at or above
  // it takes the new entry and every cell after it takes its lower neighbor's entry.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_INSERT: begin
        if (!lt) begin
          if (IDX == 0 || prev_lt) begin
            key <= cmd.key;
            val <= cmd.val;
          end else begin
            key <= prev_key;
            val <= prev_val;
          end
        end
      end
      CMD_SHIFT_DOWN: begin
        key <= next_key;
        val <= next_val;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/unique_key_double_ended_pq_unit.sv
// ----------------------------------------------------------------------------
// unique_key_double_ended_pq_unit
// Double-ended priority queue with unique costs, built as a sorted cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: insert (beauty, cost), remove highest cost or
//   remove lowest cost. rsp returns exactly one result per request: status,
//   entry count after the request, and the running sums of beauty and cost.
//   A request passes through acceptance, a scan state in which every
//   cell compares its cost with the request and the group match registers
//   load, and an apply state that resolves the match tree, shifts the chain
//   and loads the result register. The block takes one request at a time: it
//   accepts a new request only once the apply state of the last one is done.
//   The result register stands apart from the request side: a new request is
//   accepted while a result still waits. If rsp stalls, the apply state waits
//   until the result register is free.
//   Reset empties the queue and clears the sums at once; the cell contents
//   are not cleared, since only positions below the count are ever used.
// ----------------------------------------------------------------------------
module unique_key_double_ended_pq_unit #(
  parameter int CAPACITY = udpq_pkg::UDPQ_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  udpq_req_if.sink  req,
  udpq_rsp_if.source rsp
);
  import udpq_pkg::*;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int GROUP   = UDPQ_GROUP;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t              state;
  logic [TYPE_W-1:0]   op_type;
  logic [VAL_W-1:0]    op_beauty;
  logic [KEY_W-1:0]    op_cost;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [SUM_W-1:0]    beauty_sum;
  logic [SUM_W-1:0]    beauty_sum_next;
  logic [SUM_W-1:0]    cost_sum;
  logic [SUM_W-1:0]    cost_sum_next;
  logic [ST_W-1:0]     status_next;
  logic                rsp_valid;
  rsp_t                rsp_data;
  logic                fire;
  logic                dup;
  logic                full;
  logic                empty;
  logic [KEY_W-1:0]    top_key;
  logic [VAL_W-1:0]    top_val;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  cell_cmd_t           cmd;
  cell_cmd_t           cell_cmd;

  logic [KEY_W-1:0]    cell_key [CAPACITY];
  logic [VAL_W-1:0]    cell_val [CAPACITY];
  logic                cell_lt  [CAPACITY];
  logic                cell_eq  [CAPACITY];
  logic                cell_top [CAPACITY];

  logic                grp_dup     [NGROUPS];
  logic [KEY_W-1:0]    grp_top_key [NGROUPS];
  logic [VAL_W-1:0]    grp_top_val [NGROUPS];

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign fire  = (state == S_APPLY) && (!rsp_valid || rsp.ready);
  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // Cell chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] pk;
    logic [VAL_W-1:0] pv;
    logic             plt;
    logic [KEY_W-1:0] nk;
    logic [VAL_W-1:0] nv;

    if (i == 0) begin : g_first
      assign pk  = '0;
      assign pv  = '0;
      assign plt = 1'b0;
    end else begin : g_mid
      assign pk  = cell_key[i-1];
      assign pv  = cell_val[i-1];
      assign plt = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nk = cell_key[i];
      assign nv = cell_val[i];
    end else begin : g_inner
      assign nk = cell_key[i+1];
      assign nv = cell_val[i+1];
    end

    udpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .count    (count),
      .cmd      (cell_cmd),
      .prev_key (pk),
      .prev_val (pv),
      .prev_lt  (plt),
      .next_key (nk),
      .next_val (nv),
      .key      (cell_key[i]),
      .val      (cell_val[i]),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i]),
      .top      (cell_top[i])
    );
  end

  // First level of the match tree: one register set per group of cells.
  for (genvar g = 0; g < NGROUPS; g++) begin : g_group
    always_ff @(posedge clk) begin
      logic             d;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      d = 1'b0;
      k = '0;
      v = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < CAPACITY) begin
          d = d | cell_eq[g*GROUP+j];
          k = k | ({KEY_W{cell_top[g*GROUP+j]}} & cell_key[g*GROUP+j]);
          v = v | ({VAL_W{cell_top[g*GROUP+j]}} & cell_val[g*GROUP+j]);
        end
      end
      grp_dup[g]     <= d;
      grp_top_key[g] <= k;
      grp_top_val[g] <= v;
    end
  end

  always_comb begin
    dup     = 1'b0;
    top_key = '0;
    top_val = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      dup     = dup | grp_dup[g];
      top_key = top_key | grp_top_key[g];
      top_val = top_val | grp_top_val[g];
    end
  end

  always_comb begin
    status_next     = ST_IGNORED;
    count_next      = count;
    beauty_sum_next = beauty_sum;
    cost_sum_next   = cost_sum;
    cmd.op          = CMD_HOLD;
    cmd.key         = op_cost;
    cmd.val         = op_beauty;
    case (op_type)
      REQ_INSERT: begin
        if (dup) begin
          status_next = ST_DUPLICATE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next     = ST_INSERTED;
          count_next      = count + CNT_W'(1);
          beauty_sum_next = beauty_sum + SUM_W'(op_beauty);
          cost_sum_next   = cost_sum + SUM_W'(op_cost);
          cmd.op          = CMD_INSERT;
        end
      end
      REQ_POP_HIGH: begin
        if (!empty) begin
          status_next     = ST_REMOVED;
          count_next      = count - CNT_W'(1);
          beauty_sum_next = beauty_sum - SUM_W'(top_val);
          cost_sum_next   = cost_sum - SUM_W'(top_key);
        end
      end
      REQ_POP_LOW: begin
        if (!empty) begin
          status_next     = ST_REMOVED;
          count_next      = count - CNT_W'(1);
          beauty_sum_next = beauty_sum - SUM_W'(cell_val[0]);
          cost_sum_next   = cost_sum - SUM_W'(cell_key[0]);
          cmd.op          = CMD_SHIFT_DOWN;
        end
      end
      default: begin
      end
    endcase

    cell_cmd = cmd;
    if (!fire) begin
      cell_cmd.op = CMD_HOLD;
    end
    count_ext = {{COUNT_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      beauty_sum <= '0;
      cost_sum   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (fire) begin
        count      <= count_next;
        beauty_sum <= beauty_sum_next;
        cost_sum   <= cost_sum_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_type   <= req.data.req_type;
      op_beauty <= req.data.beauty;
      op_cost   <= req.data.cost;
    end
    if (fire) begin
      rsp_data.status       <= status_next;
      rsp_data.entry_count  <= count_ext[COUNT_W-1:0];
      rsp_data.beauty_total <= beauty_sum_next;
      rsp_data.cost_total   <= cost_sum_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("applied request did not produce a result");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && status_next == ST_INSERTED) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count by one");

  a_dup_no_change: assert property (@(posedge clk) disable iff (rst)
    (fire && status_next == ST_DUPLICATE) |=> $stable(count) && $stable(cost_sum))
    else $error("duplicate insert changed the queue");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the unique-cost double-ended priority queue. A predictor keeps
// its own sorted copy of the entries and the running sums. Each result that
// comes back is checked field by field against the prediction for the oldest
// open request. The stimulus runs the queue empty, fills it to capacity, and
// then churns it. Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import udpq_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  udpq_req_if req_ch ();
  udpq_rsp_if rsp_ch ();

  unique_key_double_ended_pq_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted contents of the queue, sorted by ascending cost.
  logic [KEY_W-1:0] held_cost[$];
  logic [VAL_W-1:0] held_beauty[$];
  logic [SUM_W-1:0] beauty_sum = '0;
  logic [SUM_W-1:0] cost_sum = '0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int fail_count = 0;
  int reqs_accepted = 0;
  int results_seen = 0;
  int status_seen[8] = '{default: 0};
  int idle_cycles = 0;

  int unsigned req_gap = 0;
  int unsigned rsp_stall = 0;
  logic req_burst = 1'b0;
  logic rsp_burst = 1'b0;

  function automatic rsp_t predict_response(req_t r);
    rsp_t o;
    int pos;
    logic [ST_W-1:0] st;
    case (r.req_type)
      REQ_INSERT: begin
        pos = 0;
        while (pos < held_cost.size() && held_cost[pos] < r.cost) pos++;
        if (pos < held_cost.size() && held_cost[pos] == r.cost) begin
          st = ST_DUPLICATE;
        end else if (held_cost.size() >= UDPQ_CAPACITY) begin
          st = ST_FULL;
        end else begin
          held_cost.insert(pos, r.cost);
          held_beauty.insert(pos, r.beauty);
          beauty_sum = beauty_sum + SUM_W'(r.beauty);
          cost_sum = cost_sum + SUM_W'(r.cost);
          st = ST_INSERTED;
        end
      end
      REQ_POP_HIGH: begin
        if (held_cost.size() == 0) begin
          st = ST_IGNORED;
        end else begin
          beauty_sum = beauty_sum - SUM_W'(held_beauty.pop_back());
          cost_sum = cost_sum - SUM_W'(held_cost.pop_back());
          st = ST_REMOVED;
        end
      end
      REQ_POP_LOW: begin
        if (held_cost.size() == 0) begin
          st = ST_IGNORED;
        end else begin
          beauty_sum = beauty_sum - SUM_W'(held_beauty.pop_front());
          cost_sum = cost_sum - SUM_W'(held_cost.pop_front());
          st = ST_REMOVED;
        end
      end
      default: st = ST_IGNORED;
    endcase
    o.status = st;
    o.entry_count = COUNT_W'(held_cost.size());
    o.beauty_total = beauty_sum;
    o.cost_total = cost_sum;
    return o;
  endfunction

  // Random 20-bit field value, used for both beauty and cost.
  function automatic logic [VAL_W-1:0] rand_field();
    return VAL_W'($urandom_range(0, 1048575));
  endfunction

  function automatic void queue_request(logic [TYPE_W-1:0] kind, logic [VAL_W-1:0] beauty,
                                        logic [KEY_W-1:0] cost);
    req_t r;
    r.req_type = kind;
    r.beauty = beauty;
    r.cost = cost;
    pending_reqs.push_back(r);
  endfunction

  // Request driver: a random gap follows each request, with bursts of no gaps.
  always @(posedge clk) begin : req_driver
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      req_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_gap != 0) begin
        req_ch.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
        if ($urandom_range(0, 63) == 0) req_burst <= !req_burst;
        req_gap <= req_burst ? 0 : $urandom_range(0, 11);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted request and checks every result.
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    int unsigned stall;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(predict_response(req_ch.data));
        reqs_accepted++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (rsp_ch.data.status <= ST_FULL) status_seen[rsp_ch.data.status]++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with no open request: expected none, actual %p",
                   $time, rsp_ch.data);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp_ch.data.status);
            fail_count++;
          end
          if (rsp_ch.data.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.entry_count, rsp_ch.data.entry_count);
            fail_count++;
          end
          if (rsp_ch.data.beauty_total !== want.beauty_total) begin
            $display("%0t: beauty_total mismatch: expected %0d, actual %0d",
                     $time, want.beauty_total, rsp_ch.data.beauty_total);
            fail_count++;
          end
          if (rsp_ch.data.cost_total !== want.cost_total) begin
            $display("%0t: cost_total mismatch: expected %0d, actual %0d",
                     $time, want.cost_total, rsp_ch.data.cost_total);
            fail_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) rsp_burst <= !rsp_burst;
        stall = rsp_burst ? 0 : $urandom_range(0, 11);
        rsp_stall <= stall;
        rsp_ch.ready <= (stall == 0);
      end else if (rsp_stall != 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp_ch.ready <= (rsp_stall == 1);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on either channel.
  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    logic [KEY_W-1:0] fill_cost[UDPQ_CAPACITY];
    int unsigned step;
    int unsigned offset;
    int pick;
    int tail;

    // Directed part: empty-store removals, extreme fields, duplicates, and
    // removal from both ends down to empty again.
    queue_request(REQ_POP_HIGH, 20'hFFFFF, 20'hFFFFF);
    queue_request(REQ_POP_LOW, 20'h00000, 20'h00000);
    queue_request(REQ_UNUSED, 20'hFFFFF, 20'h00000);
    queue_request(REQ_INSERT, 20'hFFFFF, 20'hFFFFF);
    queue_request(REQ_INSERT, 20'h00000, 20'h00000);
    queue_request(REQ_INSERT, 20'h12345, 20'h80000);
    queue_request(REQ_INSERT, 20'hFFFFF, 20'h80000);
    queue_request(REQ_INSERT, 20'h54321, 20'h00000);
    queue_request(REQ_INSERT, 20'h00001, 20'h00001);
    queue_request(REQ_INSERT, 20'h55555, 20'hFFFFE);
    queue_request(REQ_UNUSED, 20'hAAAAA, 20'h55555);
    queue_request(REQ_POP_LOW, 20'h0F0F0, 20'hF0F0F);
    queue_request(REQ_POP_HIGH, 20'hF0F0F, 20'h0F0F0);
    queue_request(REQ_POP_LOW, 20'h00000, 20'hFFFFF);
    queue_request(REQ_POP_HIGH, 20'hFFFFF, 20'h00000);
    queue_request(REQ_POP_LOW, 20'h33333, 20'hCCCCC);
    queue_request(REQ_POP_LOW, 20'hCCCCC, 20'h33333);
    queue_request(REQ_INSERT, 20'hAAAAA, 20'h00007);
    queue_request(REQ_POP_HIGH, 20'h00000, 20'h00000);

    // Fill the empty store to capacity with unique costs in scrambled order.
    // The upper ten cost bits walk a permutation; the lower ten never reach
    // all ones, so such costs are always new later on.
    step = ($urandom_range(0, 511) << 1) | 1;
    offset = $urandom_range(0, UDPQ_CAPACITY - 1);
    for (int k = 0; k < UDPQ_CAPACITY; k++) begin
      fill_cost[k] = {10'((k * step + offset) % UDPQ_CAPACITY), 10'($urandom_range(0, 1022))};
      if (k > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_request(REQ_UNUSED, rand_field(), rand_field());
        end else begin
          queue_request(REQ_INSERT, rand_field(), fill_cost[$urandom_range(0, k - 1)]);
        end
      end
      queue_request(REQ_INSERT, rand_field(), fill_cost[k]);
    end

    // Store is full: new costs get dropped, held costs count as duplicates.
    for (int k = 0; k < 30; k++) begin
      if (k % 2 == 0) begin
        queue_request(REQ_INSERT, rand_field(), {10'($urandom_range(0, 1023)), 10'h3FF});
      end else begin
        queue_request(REQ_INSERT, rand_field(),
                      fill_cost[$urandom_range(0, UDPQ_CAPACITY - 1)]);
      end
    end

    // Churn from a full store, leaning toward removal.
    for (int k = 0; k < 300; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_request(REQ_POP_HIGH, rand_field(), rand_field());
      end else if (pick < 65) begin
        queue_request(REQ_POP_LOW, rand_field(), rand_field());
      end else if (pick < 80) begin
        queue_request(REQ_INSERT, rand_field(), rand_field());
      end else if (pick < 95) begin
        queue_request(REQ_INSERT, rand_field(),
                      fill_cost[$urandom_range(0, UDPQ_CAPACITY - 1)]);
      end else begin
        queue_request(REQ_UNUSED, rand_field(), rand_field());
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (idle_cycles < IDLE_LIMIT &&
           (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)) begin
      @(negedge clk);
    end
    tail = 0;
    while (idle_cycles < IDLE_LIMIT && tail < TAIL_CYCLES) begin
      @(negedge clk);
      tail++;
    end

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still open",
               $time, IDLE_LIMIT, expected_rsps.size());
      $display("Some tests failed");
    end else begin
      if (expected_rsps.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_rsps.size());
        fail_count++;
      end
      $display("Covered %0d requests, %0d results: %0d inserted, %0d duplicate, %0d removed,",
               reqs_accepted, results_seen, status_seen[ST_INSERTED],
               status_seen[ST_DUPLICATE], status_seen[ST_REMOVED]);
      $display("  %0d ignored and %0d dropped on a full store; %0d mismatches.",
               status_seen[ST_IGNORED], status_seen[ST_FULL], fail_count);
      if (fail_count == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
    end
    $finish;
  end

endmodule
